// ----- rtl/olsh_pkg.sv -----
// Shared types, coefficients and gamma tables for the OKLab lightness shift block.
package olsh_pkg;

  // Packed lookup table of 256 entries, 17 bits each
  typedef logic [255:0][16:0] lut17_t;

  localparam logic [63:0] ONE30 = 64'd1 << 30;
  // Divisor that scales the Q0.30 encode numerator back to a code
  localparam logic [63:0] ENC_DIV = 64'd1000 * ONE30;

  // Number of result bits that the cube root search resolves (bits 30..13 of Q0.30)
  localparam int CR_BITS = 18;
  // Bits of the output code resolved by the threshold search
  localparam int CODE_BITS = 8;

  // Linear RGB to LMS, unsigned Q0.16
  localparam logic [15:0] MX_LMS [3][3] = '{
    '{16'd27015, 16'd35149, 16'd3372},
    '{16'd13887, 16'd44610, 16'd7039},
    '{16'd5787,  16'd18463, 16'd41286}};

  // Cube-rooted LMS to OKLab, signed
  localparam logic signed [18:0] MX_LAB [3][3] = '{
    '{19'sd13792,  19'sd52011,   -19'sd267},
    '{19'sd129630, -19'sd159160, 19'sd29530},
    '{19'sd1697,   19'sd51300,   -19'sd52997}};

  // OKLab a and b back to cube-rooted LMS (L term has unit weight)
  localparam logic signed [17:0] MX_INV_LAB [3][2] = '{
    '{18'sd25974, 18'sd14143},
    '{-18'sd6918, -18'sd4185},
    '{-18'sd5864, -18'sd84639}};

  // LMS back to linear RGB, signed
  localparam logic signed [19:0] MX_RGB [3][3] = '{
    '{20'sd267173, -20'sd216774, 20'sd15137},
    '{-20'sd83128, 20'sd171033,  -20'sd22369},
    '{-20'sd275,   -20'sd46099,  20'sd111910}};

  // y^n in Q0.30, truncating after each multiply (elaboration only)
  function automatic logic [63:0] pow_q30(input logic [63:0] y, input int n);
    logic [63:0] acc;
    acc = ONE30;
    for (int i = 0; i < n; i++) begin
      acc = (acc * y) >> 30;
    end
    return acc;
  endfunction

  // Largest y in 0..2^30 with pow_q30(y, n) <= t (elaboration only)
  function automatic logic [63:0] root_q30(input logic [63:0] t, input int n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = ONE30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (pow_q30(mid, n) <= t) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // sRGB code to linear light, Q0.16
  function automatic logic [63:0] dec_val(input logic [63:0] c);
    logic [63:0] u;
    if (c <= 64'd10) begin
      return (c * 64'd655360 + 64'd16473) / 64'd32946;
    end
    u = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
    return (pow_q30(root_q30(u, 5), 12) + 64'd8192) >> 14;
  endfunction

  // Linear light in 0..65536 to sRGB code
  function automatic logic [63:0] enc_val(input logic [63:0] r);
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] code;
    if (r <= 64'd205) begin
      return (r * 64'd32946 + 64'd327680) / 64'd655360;
    end
    p = pow_q30(root_q30(r << 14, 12), 5);
    num = 64'd255 * (64'd1055 * p - 64'd55 * ONE30);
    code = (num + 64'd500 * ONE30) / ENC_DIV;
    return (code > 64'd255) ? 64'd255 : code;
  endfunction

  function automatic lut17_t build_dec();
    lut17_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 17'(dec_val(64'(i)));
    end
    return lut;
  endfunction

  // Smallest linear value that encodes to at least each code
  function automatic lut17_t build_thr();
    lut17_t lut;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lut[0] = 17'd0;
    lo = 64'd0;
    for (int k = 1; k < 256; k++) begin
      hi = 64'd65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (enc_val(mid) >= 64'(k)) begin
          hi = mid;
        end else begin
          lo = mid + 64'd1;
        end
      end
      lut[k] = 17'(lo);
    end
    return lut;
  endfunction

  localparam lut17_t DEC_LUT = build_dec();
  localparam lut17_t ENC_THR = build_thr();

endpackage

// ----- rtl/olsh_if.sv -----
// Pixel and configuration channel interfaces of the OKLab lightness shift block.
interface olsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface olsh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface olsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] delta_lightness;
  modport source (output valid, delta_lightness, input ready);
  modport sink (input valid, delta_lightness, output ready);
endinterface

// ----- rtl/oklab_lightness_shift.sv -----
// Top level of the OKLab lightness shift pixel pipeline.
//
//  channel   dir   handshake      payload
//  in_px     in    valid/ready    red_in, green_in, blue_in, alpha_in
//  out_px    out   valid/ready    red_out, green_out, blue_out, alpha_out
//  cfg_wr    in    valid/ready    delta_lightness (always ready)
//
// One pixel enters per clock unless the pipe is full and the result waits.
// Most of the depth comes from the cube root search: 18 result bits, two stages each
// (square, then cube and compare), plus 8 stages of sRGB threshold search.
// A stage holds only when it and every stage after it are full and the result waits;
// bubbles close up, so a new request is taken while a result waits if a stage is empty.
// rst_n clears the valid bits and the lightness offset; data needs no reset.
module oklab_lightness_shift (
  input  logic       clk,
  input  logic       rst_n,
  olsh_in_if.sink    in_px,
  olsh_out_if.source out_px,
  olsh_cfg_if.sink   cfg_wr
);

  localparam int CB = olsh_pkg::CR_BITS;
  localparam int NB = olsh_pkg::CODE_BITS;
  localparam int S_CUBE = 3;
  localparam int S_CR = S_CUBE + 2 * CB;
  localparam int S_SRCH = S_CR + 10;
  localparam int NST = S_SRCH + NB;
  localparam int LAST = NST - 1;

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;
  logic [7:0] a_r [NST];
  logic signed [15:0] dl_r;

  // Stage data
  logic [16:0] lin_r [3];
  logic [32:0] lp_r [3][3];
  logic [16:0] lv_r [3];
  logic [17:0] ya_r [CB][3];
  logic [31:0] sq_r [CB][3];
  logic [16:0] ta_r [CB][3];
  logic [17:0] yb_r [CB][3];
  logic [16:0] tb_r [CB][3];
  logic [16:0] cr_r [3];
  logic [36:0] lbp_r [3][3];
  logic [17:0] lab_r [3];
  logic [14:0] lc_r;
  logic [17:0] la_r;
  logic [17:0] lb_r;
  logic [35:0] ip_r [3][2];
  logic [14:0] lc2_r;
  logic [19:0] t_r [3];
  logic [21:0] sqt_r [3];
  logic [19:0] t2_r [3];
  logic [23:0] lms_r [3];
  logic [43:0] rp_r [3][3];
  logic [16:0] ev_r [3];
  logic [NB-1:0] code_r [NB][3];
  logic [16:0] sv_r [NB][3];

  logic [7:0] pix_in [3];

  assign pix_in[0] = in_px.red_in;
  assign pix_in[1] = in_px.green_in;
  assign pix_in[2] = in_px.blue_in;

  // Take the offset register write
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= '0;
    end else if (cfg_wr.valid) begin
      dl_r <= cfg_wr.delta_lightness;
    end
  end

  // A stage advances when the result is taken or it or any later stage is empty
  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_rdy
      assign rdy[k] = out_px.ready | ~(&v_r[LAST:k]);
    end
  endgenerate

  assign in_px.ready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_px.valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // Carry alpha along the pipe
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_r[0] <= in_px.alpha_in;
    end
    for (int s = 1; s < NST; s++) begin
      if (rdy[s]) begin
        a_r[s] <= a_r[s-1];
      end
    end
  end

  // Decode sRGB to linear light
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        lin_r[i] <= olsh_pkg::DEC_LUT[pix_in[i]];
      end
    end
  end

  // LMS mix: products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lp_r[i][j] <= 33'(olsh_pkg::MX_LMS[i][j]) * 33'(lin_r[j]);
        end
      end
    end
  end

  // LMS mix: sum, round and clamp to 1.0
  always_ff @(posedge clk) begin
    logic [34:0] sm;
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        sm = 35'(lp_r[i][0]) + 35'(lp_r[i][1]) + 35'(lp_r[i][2]) + 35'd32768;
        lv_r[i] <= (sm[34:16] > 19'd65536) ? 17'd65536 : sm[32:16];
      end
    end
  end

  // Cube root, one result bit per pair of stages
  genvar j;
  generate
    for (j = 0; j < CB; j++) begin : g_cr
      logic [17:0] yp [3];
      logic [16:0] vp [3];
      logic [17:0] ca [3];
      logic [17:0] cb [3];
      logic [49:0] cube [3];

      // Start from zero, or take the partial root of the previous bit
      if (j == 0) begin : g_head
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            yp[i] = 18'd0;
            vp[i] = lv_r[i];
          end
        end
      end else begin : g_tail
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            yp[i] = yb_r[j-1][i];
            vp[i] = tb_r[j-1][i];
          end
        end
      end

      always_comb begin
        for (int i = 0; i < 3; i++) begin
          ca[i] = yp[i] | (18'd1 << (CB - 1 - j));
          cb[i] = ya_r[j][i] | (18'd1 << (CB - 1 - j));
          cube[i] = 50'(sq_r[j][i]) * 50'(cb[i]);
        end
      end

      // Square the candidate
      always_ff @(posedge clk) begin
        logic [35:0] p2;
        if (rdy[S_CUBE + 2 * j]) begin
          for (int i = 0; i < 3; i++) begin
            p2 = 36'(ca[i]) * 36'(ca[i]);
            sq_r[j][i] <= p2[35:4];
            ya_r[j][i] <= yp[i];
            ta_r[j][i] <= vp[i];
          end
        end
      end

      // Cube, compare with the target, keep or drop the bit
      always_ff @(posedge clk) begin
        if (rdy[S_CUBE + 2 * j + 1]) begin
          for (int i = 0; i < 3; i++) begin
            yb_r[j][i] <= (cube[i][49:17] <= {2'b00, ta_r[j][i], 14'd0}) ?
                          cb[i] : ya_r[j][i];
            tb_r[j][i] <= ta_r[j][i];
          end
        end
      end
    end
  endgenerate

  // Round the root to Q0.16
  always_ff @(posedge clk) begin
    logic [17:0] rs;
    if (rdy[S_CR]) begin
      for (int i = 0; i < 3; i++) begin
        rs = yb_r[CB-1][i] + 18'd1;
        cr_r[i] <= rs[17:1];
      end
    end
  end

  // OKLab mix: products
  always_ff @(posedge clk) begin
    if (rdy[S_CR + 1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int m = 0; m < 3; m++) begin
          lbp_r[i][m] <= 37'($signed({1'b0, cr_r[m]})) * 37'(olsh_pkg::MX_LAB[i][m]);
        end
      end
    end
  end

  // OKLab mix: sum and round
  always_ff @(posedge clk) begin
    logic [38:0] sm;
    if (rdy[S_CR + 2]) begin
      for (int i = 0; i < 3; i++) begin
        sm = 39'($signed(lbp_r[i][0])) + 39'($signed(lbp_r[i][1])) +
             39'($signed(lbp_r[i][2])) + 39'd131072;
        lab_r[i] <= sm[35:18];
      end
    end
  end

  // Add the offset to L and clamp to 0..1
  always_ff @(posedge clk) begin
    logic [18:0] ls;
    if (rdy[S_CR + 3]) begin
      ls = 19'($signed(lab_r[0])) + 19'(dl_r);
      if (ls[18]) begin
        lc_r <= 15'd0;
      end else if (ls > 19'd16384) begin
        lc_r <= 15'd16384;
      end else begin
        lc_r <= ls[14:0];
      end
      la_r <= lab_r[1];
      lb_r <= lab_r[2];
    end
  end

  // Inverse OKLab mix: products
  always_ff @(posedge clk) begin
    if (rdy[S_CR + 4]) begin
      for (int i = 0; i < 3; i++) begin
        ip_r[i][0] <= 36'(olsh_pkg::MX_INV_LAB[i][0]) * 36'($signed(la_r));
        ip_r[i][1] <= 36'(olsh_pkg::MX_INV_LAB[i][1]) * 36'($signed(lb_r));
      end
      lc2_r <= lc_r;
    end
  end

  // Inverse OKLab mix: sum and round to Q0.16
  always_ff @(posedge clk) begin
    logic [37:0] sm;
    if (rdy[S_CR + 5]) begin
      for (int i = 0; i < 3; i++) begin
        sm = 38'({lc2_r, 16'd0}) + 38'($signed(ip_r[i][0])) +
             38'($signed(ip_r[i][1])) + 38'd8192;
        t_r[i] <= sm[33:14];
      end
    end
  end

  // Square
  always_ff @(posedge clk) begin
    logic [39:0] pr;
    if (rdy[S_CR + 6]) begin
      for (int i = 0; i < 3; i++) begin
        pr = 40'($signed(t_r[i])) * 40'($signed(t_r[i])) + 40'd32768;
        sqt_r[i] <= pr[37:16];
        t2_r[i] <= t_r[i];
      end
    end
  end

  // Cube
  always_ff @(posedge clk) begin
    logic [41:0] pr;
    if (rdy[S_CR + 7]) begin
      for (int i = 0; i < 3; i++) begin
        pr = 42'($signed(sqt_r[i])) * 42'($signed(t2_r[i])) + 42'd32768;
        lms_r[i] <= pr[39:16];
      end
    end
  end

  // RGB mix: products
  always_ff @(posedge clk) begin
    if (rdy[S_CR + 8]) begin
      for (int i = 0; i < 3; i++) begin
        for (int m = 0; m < 3; m++) begin
          rp_r[i][m] <= 44'(olsh_pkg::MX_RGB[i][m]) * 44'($signed(lms_r[m]));
        end
      end
    end
  end

  // RGB mix: sum, round and clamp to 0..1
  always_ff @(posedge clk) begin
    logic [45:0] sm;
    if (rdy[S_CR + 9]) begin
      for (int i = 0; i < 3; i++) begin
        sm = 46'($signed(rp_r[i][0])) + 46'($signed(rp_r[i][1])) +
             46'($signed(rp_r[i][2])) + 46'd32768;
        if (sm[45]) begin
          ev_r[i] <= 17'd0;
        end else if (sm[44:16] > 29'd65536) begin
          ev_r[i] <= 17'd65536;
        end else begin
          ev_r[i] <= sm[32:16];
        end
      end
    end
  end

  // Encode: search the code thresholds one bit per stage
  genvar q;
  generate
    for (q = 0; q < NB; q++) begin : g_enc
      logic [NB-1:0] cp [3];
      logic [16:0] ep [3];
      logic [NB-1:0] cc [3];

      // Start from code zero, or take the partial code of the previous bit
      if (q == 0) begin : g_head
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            cp[i] = '0;
            ep[i] = ev_r[i];
          end
        end
      end else begin : g_tail
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            cp[i] = code_r[q-1][i];
            ep[i] = sv_r[q-1][i];
          end
        end
      end

      always_comb begin
        for (int i = 0; i < 3; i++) begin
          cc[i] = cp[i] | (NB'(1) << (NB - 1 - q));
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[S_SRCH + q]) begin
          for (int i = 0; i < 3; i++) begin
            code_r[q][i] <= (olsh_pkg::ENC_THR[cc[i]] <= ep[i]) ? cc[i] : cp[i];
            sv_r[q][i] <= ep[i];
          end
        end
      end
    end
  endgenerate

  // Drive the result channel from the last stage
  assign out_px.valid = v_r[LAST];
  assign out_px.red_out = code_r[NB-1][0];
  assign out_px.green_out = code_r[NB-1][1];
  assign out_px.blue_out = code_r[NB-1][2];
  assign out_px.alpha_out = a_r[LAST];

endmodule
